// ===== design/utf8v_pkg.sv =====
// utf8v_pkg: constants for the utf-8 stream validator
// no dependencies; imported by utf8_stream_validator
`default_nettype none

package utf8v_pkg;

  // code point register width and the continuation payload width
  localparam int unsigned CP_W  = 21;
  localparam int unsigned CONT_W = 6;

  // lead and continuation byte classes
  localparam logic [7:0] MASK_2B   = 8'hE0;
  localparam logic [7:0] LEAD_2B   = 8'hC0;
  localparam logic [7:0] MASK_3B   = 8'hF0;
  localparam logic [7:0] LEAD_3B   = 8'hE0;
  localparam logic [7:0] MASK_4B   = 8'hF8;
  localparam logic [7:0] LEAD_4B   = 8'hF0;
  localparam logic [7:0] MASK_CONT = 8'hC0;
  localparam logic [7:0] TAG_CONT  = 8'h80;
  localparam logic [7:0] OVERLONG_2B = 8'h1E;

  // sequence lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2B   = 3'd2;
  localparam logic [2:0] LEN_3B   = 3'd3;
  localparam logic [2:0] LEN_4B   = 3'd4;

  // code point limits
  localparam logic [CP_W-1:0] MIN_3B    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4B    = 21'h010000;
  localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

endpackage

`default_nettype wire

// ===== design/utf8_stream_validator.sv =====
// utf8_stream_validator: byte-serial utf-8 well-formedness checker
// depends on utf8v_pkg for byte classes and code point limits
//
// usage: one byte of a buffer is accepted per request on the input
// channel (in_valid / in_stall, payload data_byte and last). the byte
// marked last closes the buffer; for it, and only for it, one request
// leaves on the output channel (out_valid / out_stall, payload
// valid_res), 1 when the whole buffer was well-formed utf-8.
// path: a last byte passes the input register, then the result register,
// on its way to the output channel.
// throughput: one byte per cycle while in_stall is low, set by the
// combinational state update between input and decoder state registers.
// stall: while a result waits under out_stall, bytes that are not last
// keep flowing; a second last byte waits in the input register and
// in_stall rises until the result is taken.
// reset: rst clears both valid flags and the decoder state; the next
// byte accepted starts a new buffer. after each last byte the decoder
// state returns to its reset value as well.
`default_nettype none

module utf8_stream_validator
  import utf8v_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            valid_res
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_adv;

  // decoder state
  logic [1:0]      pending, pending_next;
  logic [2:0]      seq_len, seq_len_next;
  logic [CP_W-1:0] cp, cp_next;
  logic            failed, failed_next;

  // byte decode
  logic            is_cont;
  logic [CP_W-1:0] cp_shift;
  logic            bad_end;
  logic            res_bit;

  // the input stage moves on unless a result is blocked at the output
  assign s1_adv   = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  // continuation append and end-of-sequence range checks
  assign is_cont  = (s1_byte & MASK_CONT) == TAG_CONT;
  assign cp_shift = {cp[CP_W-CONT_W-1:0], s1_byte[CONT_W-1:0]};
  assign bad_end  = ((seq_len == LEN_3B) && (cp_shift < MIN_3B))
                 || ((seq_len == LEN_4B) && (cp_shift < MIN_4B))
                 || (cp_shift > MAX_CP)
                 || ((cp_shift >= SURR_LO) && (cp_shift <= SURR_HI));

  // next decoder state for the byte in the input register
  always_comb begin
    pending_next = pending;
    seq_len_next = seq_len;
    cp_next      = cp;
    failed_next  = failed;
    if (!failed) begin
      if (pending == 2'd0) begin
        if (!s1_byte[7]) begin
          failed_next = 1'b0;
        end else if ((s1_byte & MASK_2B) == LEAD_2B) begin
          if ((s1_byte & OVERLONG_2B) == 8'h00) begin
            failed_next = 1'b1;
          end else begin
            pending_next = 2'd1;
            seq_len_next = LEN_2B;
            cp_next      = {{(CP_W-5){1'b0}}, s1_byte[4:0]};
          end
        end else if ((s1_byte & MASK_3B) == LEAD_3B) begin
          pending_next = 2'd2;
          seq_len_next = LEN_3B;
          cp_next      = {{(CP_W-4){1'b0}}, s1_byte[3:0]};
        end else if ((s1_byte & MASK_4B) == LEAD_4B) begin
          pending_next = 2'd3;
          seq_len_next = LEN_4B;
          cp_next      = {{(CP_W-3){1'b0}}, s1_byte[2:0]};
        end else begin
          failed_next = 1'b1;
        end
      end else if (!is_cont) begin
        failed_next = 1'b1;
      end else if (pending == 2'd1) begin
        pending_next = 2'd0;
        seq_len_next = LEN_NONE;
        cp_next      = '0;
        failed_next  = bad_end;
      end else begin
        pending_next = pending - 2'd1;
        cp_next      = cp_shift;
      end
    end
  end

  assign res_bit = !failed_next && (pending_next == 2'd0);

  // decoder state registers, cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      seq_len <= LEN_NONE;
      cp      <= '0;
      failed  <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last) begin
        pending <= 2'd0;
        seq_len <= LEN_NONE;
        cp      <= '0;
        failed  <= 1'b0;
      end else begin
        pending <= pending_next;
        seq_len <= seq_len_next;
        cp      <= cp_next;
        failed  <= failed_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      valid_res <= res_bit;
    end
  end

  // no open sequence leaves a stale length or code point behind
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (pending == 2'd0) |-> (seq_len == LEN_NONE && cp == '0))
    else $error("idle decoder holds sequence state");

  // an open sequence is longer than its remaining continuation count
  a_len_match: assert property (@(posedge clk) disable iff (rst)
    (pending != 2'd0) |-> (seq_len > {1'b0, pending} && seq_len <= LEN_4B))
    else $error("sequence length and pending count disagree");

  // a last byte leaving the input register always raises a result
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> out_valid)
    else $error("last byte produced no result");

  // a blocked result stalls only a last byte
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_last && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // reset empties both stages
  a_reset: assert property (@(posedge clk)
    rst |=> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
